// File: rtl/dda_pkg.sv
package dda_pkg;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  localparam int COLOR_BITS = 24;

endpackage

// File: rtl/dda_line_rasterizer_core.sv
// a step beat's pixel is registered and shows on out_* in the cycle after it is accepted
// throughput: one step beat per cycle while out_ready stays high
// a start beat of nonzero length holds in_ready low while the bit-serial restoring
// dividers (one per axis, sharing the divisor) run, one quotient bit per cycle each
// reset: synchronous active-low rst_n clears the state, the pixel count and out_valid
module dda_line_rasterizer_core #(
  parameter int COORD_BITS = 10,
  parameter int FRAC_BITS  = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_operation,
  input  logic [COORD_BITS-1:0]          in_start_x,
  input  logic [COORD_BITS-1:0]          in_start_y,
  input  logic [COORD_BITS-1:0]          in_end_x,
  input  logic [COORD_BITS-1:0]          in_end_y,
  input  logic [dda_pkg::COLOR_BITS-1:0] in_pixel_color,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [COORD_BITS-1:0]          out_pixel_x,
  output logic [COORD_BITS-1:0]          out_pixel_y,
  output logic [dda_pkg::COLOR_BITS-1:0] out_color,
  output logic                           out_last_pixel
);
  import dda_pkg::*;

  localparam int ACC_BITS  = COORD_BITS + FRAC_BITS;
  localparam int INC_BITS  = FRAC_BITS + 2;
  localparam int CNT_BITS  = COORD_BITS + 1;
  localparam int Q_BITS    = FRAC_BITS + 1;
  localparam int REM_BITS  = COORD_BITS + 1;
  localparam int DCNT_BITS = $clog2(FRAC_BITS + 1);

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } state_t;

  state_t                  state_r;
  logic [ACC_BITS-1:0]     acc_x_r;
  logic [ACC_BITS-1:0]     acc_y_r;
  logic [INC_BITS-1:0]     inc_x_r;
  logic [INC_BITS-1:0]     inc_y_r;
  logic [CNT_BITS-1:0]     remaining_r;
  logic [COLOR_BITS-1:0]   line_color_r;
  logic [COORD_BITS-1:0]   len_r;
  logic [REM_BITS-1:0]     rem_x_r;
  logic [REM_BITS-1:0]     rem_y_r;
  logic [Q_BITS-1:0]       q_x_r;
  logic [Q_BITS-1:0]       q_y_r;
  logic                    neg_x_r;
  logic                    neg_y_r;
  logic [DCNT_BITS-1:0]    dcnt_r;
  logic                    out_valid_r;
  logic [COORD_BITS-1:0]   out_pixel_x_r;
  logic [COORD_BITS-1:0]   out_pixel_y_r;
  logic [COLOR_BITS-1:0]   out_color_r;
  logic                    out_last_pixel_r;

  logic                    in_fire;
  logic                    step_fire;
  logic                    neg_x;
  logic                    neg_y;
  logic [COORD_BITS-1:0]   span_x;
  logic [COORD_BITS-1:0]   span_y;
  logic [COORD_BITS-1:0]   len;
  logic [ACC_BITS-1:0]     half;
  logic [REM_BITS-1:0]     len_ext;
  logic                    d_x;
  logic                    d_y;
  logic [REM_BITS-1:0]     diff_x;
  logic [REM_BITS-1:0]     diff_y;
  logic [REM_BITS-1:0]     rem_x_nxt;
  logic [REM_BITS-1:0]     rem_y_nxt;
  logic [Q_BITS-1:0]       q_x_nxt;
  logic [Q_BITS-1:0]       q_y_nxt;
  logic [INC_BITS-1:0]     q_x_ext;
  logic [INC_BITS-1:0]     q_y_ext;
  logic [ACC_BITS-1:0]     acc_x_nxt;
  logic [ACC_BITS-1:0]     acc_y_nxt;

  assign in_ready  = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign in_fire   = in_valid && in_ready;
  assign step_fire = in_fire && (in_operation == OP_STEP) && (remaining_r != '0);

  // spans and line length
  assign neg_x  = in_end_x < in_start_x;
  assign neg_y  = in_end_y < in_start_y;
  assign span_x = neg_x ? (in_start_x - in_end_x) : (in_end_x - in_start_x);
  assign span_y = neg_y ? (in_start_y - in_end_y) : (in_end_y - in_start_y);
  assign len    = (span_x >= span_y) ? span_x : span_y;
  assign half   = ACC_BITS'(1) << (FRAC_BITS - 1);

  // one restoring step per axis, sharing the divisor
  assign len_ext   = {1'b0, len_r};
  assign d_x       = rem_x_r >= len_ext;
  assign d_y       = rem_y_r >= len_ext;
  assign diff_x    = d_x ? (rem_x_r - len_ext) : rem_x_r;
  assign diff_y    = d_y ? (rem_y_r - len_ext) : rem_y_r;
  assign rem_x_nxt = {diff_x[REM_BITS-2:0], 1'b0};
  assign rem_y_nxt = {diff_y[REM_BITS-2:0], 1'b0};
  assign q_x_nxt   = {q_x_r[Q_BITS-2:0], d_x};
  assign q_y_nxt   = {q_y_r[Q_BITS-2:0], d_y};
  assign q_x_ext   = {1'b0, q_x_nxt};
  assign q_y_ext   = {1'b0, q_y_nxt};

  // sign-extended increment added with wrap
  assign acc_x_nxt = acc_x_r + {{(ACC_BITS-INC_BITS){inc_x_r[INC_BITS-1]}}, inc_x_r};
  assign acc_y_nxt = acc_y_r + {{(ACC_BITS-INC_BITS){inc_y_r[INC_BITS-1]}}, inc_y_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      remaining_r <= '0;
    end else begin
      if (out_valid_r && out_ready && !step_fire) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_operation == OP_START) begin
              acc_x_r      <= {in_start_x, {FRAC_BITS{1'b0}}} + half;
              acc_y_r      <= {in_start_y, {FRAC_BITS{1'b0}}} + half;
              remaining_r  <= {1'b0, len};
              line_color_r <= in_pixel_color;
              len_r        <= len;
              rem_x_r      <= {1'b0, span_x};
              rem_y_r      <= {1'b0, span_y};
              neg_x_r      <= neg_x;
              neg_y_r      <= neg_y;
              q_x_r        <= '0;
              q_y_r        <= '0;
              dcnt_r       <= DCNT_BITS'(FRAC_BITS);
              if (len == '0) begin
                inc_x_r <= '0;
                inc_y_r <= '0;
              end else begin
                state_r <= ST_DIV;
              end
            end else if (remaining_r != '0) begin
              out_valid_r      <= 1'b1;
              out_pixel_x_r    <= acc_x_r[ACC_BITS-1:FRAC_BITS];
              out_pixel_y_r    <= acc_y_r[ACC_BITS-1:FRAC_BITS];
              out_color_r      <= line_color_r;
              out_last_pixel_r <= remaining_r == CNT_BITS'(1);
              acc_x_r          <= acc_x_nxt;
              acc_y_r          <= acc_y_nxt;
              remaining_r      <= remaining_r - CNT_BITS'(1);
            end
          end
        end
        ST_DIV: begin
          rem_x_r <= rem_x_nxt;
          rem_y_r <= rem_y_nxt;
          q_x_r   <= q_x_nxt;
          q_y_r   <= q_y_nxt;
          dcnt_r  <= dcnt_r - DCNT_BITS'(1);
          if (dcnt_r == '0) begin
            inc_x_r <= neg_x_r ? (INC_BITS'(0) - q_x_ext) : q_x_ext;
            inc_y_r <= neg_y_r ? (INC_BITS'(0) - q_y_ext) : q_y_ext;
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_x    = out_pixel_x_r;
  assign out_pixel_y    = out_pixel_y_r;
  assign out_color      = out_color_r;
  assign out_last_pixel = out_last_pixel_r;

`ifndef SYNTH
  a_start_divides: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_operation == OP_START && len != '0) |=> state_r == ST_DIV)
    else $error("nonzero-length start did not enter divide");

  a_pixel_from_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_fire && in_operation == OP_STEP && remaining_r != '0))
    else $error("pixel appeared without a step beat");

  a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_operation == OP_STEP && remaining_r != '0)
      |=> remaining_r == $past(remaining_r) - CNT_BITS'(1))
    else $error("pixel count did not drop by one");

  a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_pixel_r && state_r == ST_IDLE && !$past(in_fire)
      && $past(out_valid_r)) |-> remaining_r == '0 || $past(remaining_r) == remaining_r)
    else $error("count moved without a beat");
`endif

endmodule

// File: tb/dda_line_rasterizer_core_tb.sv
`timescale 1ns / 100ps

module dda_line_rasterizer_core_tb;
  import dda_pkg::*;

  localparam int COORD_BITS = 10;
  localparam int FRAC_BITS = 16;
  localparam int ACC_BITS = COORD_BITS + FRAC_BITS;
  localparam int INC_BITS = FRAC_BITS + 2;
  localparam int CNT_BITS = COORD_BITS + 1;
  localparam int COORD_MAX = (1 << COORD_BITS) - 1;
  localparam int RANDOM_BEATS = 1800;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 40;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [COLOR_BITS-1:0] color_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    color_t color;
    logic   last;
  } pixel_t;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_TYPED, ROW_NONE} row_kind_t;

  typedef struct packed {
    logic      op;
    coord_t    sx;
    coord_t    sy;
    coord_t    ex;
    coord_t    ey;
    color_t    color;
    row_kind_t kind;
    pixel_t    want;
  } stim_row_t;

  localparam pixel_t NO_PIXEL = '0;

  stim_row_t directed_rows [25] = '{
    '{OP_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    24'h000000, ROW_NONE,    NO_PIXEL},
    '{OP_START, 10'd0,    10'd0,    10'd3,    10'd0,    24'hffffff, ROW_NONE,    NO_PIXEL},
    '{OP_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    24'h000000, ROW_TYPED,
      '{10'd0, 10'd0, 24'hffffff, 1'b0}},
    '{OP_STEP,  10'd1023, 10'd1023, 10'd1023, 10'd1023, 24'hffffff, ROW_TYPED,
      '{10'd1, 10'd0, 24'hffffff, 1'b0}},
    '{OP_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    24'h000000, ROW_TYPED,
      '{10'd2, 10'd0, 24'hffffff, 1'b1}},
    '{OP_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    24'h000000, ROW_NONE,    NO_PIXEL},
    '{OP_START, 10'd5,    10'd5,    10'd5,    10'd5,    24'h123456, ROW_NONE,    NO_PIXEL},
    '{OP_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    24'h000000, ROW_NONE,    NO_PIXEL},
    '{OP_START, 10'd1023, 10'd1023, 10'd0,    10'd0,    24'h000000, ROW_NONE,    NO_PIXEL},
    '{OP_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    24'h000000, ROW_TYPED,
      '{10'd1023, 10'd1023, 24'h000000, 1'b0}},
    '{OP_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    24'h000000, ROW_TYPED,
      '{10'd1022, 10'd1022, 24'h000000, 1'b0}},
    '{OP_START, 10'd0,    10'd1023, 10'd1023, 10'd0,    24'habcdef, ROW_NONE,    NO_PIXEL},
    '{OP_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    24'h000000, ROW_TYPED,
      '{10'd0, 10'd1023, 24'habcdef, 1'b0}},
    '{OP_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    24'h000000, ROW_PREDICT, NO_PIXEL},
    '{OP_START, 10'd10,   10'd20,   10'd13,   10'd30,   24'h0f0f0f, ROW_NONE,    NO_PIXEL},
    '{OP_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    24'h000000, ROW_PREDICT, NO_PIXEL},
    '{OP_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    24'h000000, ROW_PREDICT, NO_PIXEL},
    '{OP_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    24'h000000, ROW_PREDICT, NO_PIXEL},
    '{OP_START, 10'd500,  10'd600,  10'd497,  10'd593,  24'hf0f0f0, ROW_NONE,    NO_PIXEL},
    '{OP_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    24'h000000, ROW_PREDICT, NO_PIXEL},
    '{OP_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    24'h000000, ROW_PREDICT, NO_PIXEL},
    '{OP_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    24'h000000, ROW_PREDICT, NO_PIXEL},
    '{OP_START, 10'd0,    10'd0,    10'd0,    10'd1,    24'h555555, ROW_NONE,    NO_PIXEL},
    '{OP_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    24'h000000, ROW_TYPED,
      '{10'd0, 10'd0, 24'h555555, 1'b1}},
    '{OP_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    24'h000000, ROW_NONE,    NO_PIXEL}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic in_operation;
  coord_t in_start_x;
  coord_t in_start_y;
  coord_t in_end_x;
  coord_t in_end_y;
  color_t in_pixel_color;
  logic out_valid;
  logic out_ready = 1'b0;
  coord_t out_pixel_x;
  coord_t out_pixel_y;
  color_t out_color;
  logic out_last_pixel;

  logic [ACC_BITS-1:0] x_acc = '0;
  logic [ACC_BITS-1:0] y_acc = '0;
  logic [INC_BITS-1:0] x_inc = '0;
  logic [INC_BITS-1:0] y_inc = '0;
  logic [CNT_BITS-1:0] pixels_left = '0;
  color_t line_color = '0;

  pixel_t pending_pixels[$];
  int mismatches = 0;
  int cycle_count = 0;
  int ready_hold = 0;
  bit idling_on = 1'b1;
  bit stalls_on = 1'b1;

  dda_line_rasterizer_core #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_operation  (in_operation),
    .in_start_x    (in_start_x),
    .in_start_y    (in_start_y),
    .in_end_x      (in_end_x),
    .in_end_y      (in_end_y),
    .in_pixel_color(in_pixel_color),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel_x   (out_pixel_x),
    .out_pixel_y   (out_pixel_y),
    .out_color     (out_color),
    .out_last_pixel(out_last_pixel)
  );

  always #10 clk = ~clk;

  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 30);
    return $urandom_range(0, 3);
  endfunction

  function automatic int near_coord(int c);
    return $urandom_range(c > 8 ? c - 8 : 0, c < COORD_MAX - 8 ? c + 8 : COORD_MAX);
  endfunction

  // signed per-pixel increment, truncated toward zero
  function automatic logic [INC_BITS-1:0] axis_step(int unsigned from, int unsigned to,
                                                    int unsigned len);
    int unsigned mag;
    int unsigned q;
    if (len == 0) return '0;
    mag = to < from ? from - to : to - from;
    q = (mag << FRAC_BITS) / len;
    if (to < from) q = 0 - q;
    return INC_BITS'(q);
  endfunction

  task automatic rasterize_beat(input stim_row_t b, output bit has_pixel, output pixel_t pix);
    int unsigned span_x;
    int unsigned span_y;
    int unsigned len;
    has_pixel = 1'b0;
    pix = NO_PIXEL;
    if (b.op == OP_START) begin
      span_x = b.ex >= b.sx ? b.ex - b.sx : b.sx - b.ex;
      span_y = b.ey >= b.sy ? b.ey - b.sy : b.sy - b.ey;
      len = span_x >= span_y ? span_x : span_y;
      x_inc = axis_step(b.sx, b.ex, len);
      y_inc = axis_step(b.sy, b.ey, len);
      x_acc = {b.sx, 1'b1, {(FRAC_BITS-1){1'b0}}};
      y_acc = {b.sy, 1'b1, {(FRAC_BITS-1){1'b0}}};
      pixels_left = CNT_BITS'(len);
      line_color = b.color;
    end else if (pixels_left != 0) begin
      has_pixel = 1'b1;
      pix = '{x_acc[ACC_BITS-1:FRAC_BITS], y_acc[ACC_BITS-1:FRAC_BITS], line_color,
              pixels_left == 1};
      x_acc = x_acc + {{(ACC_BITS-INC_BITS){x_inc[INC_BITS-1]}}, x_inc};
      y_acc = y_acc + {{(ACC_BITS-INC_BITS){y_inc[INC_BITS-1]}}, y_inc};
      pixels_left = pixels_left - 1'b1;
    end
  endtask

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  task automatic send_beat(input stim_row_t b);
    bit has_pixel;
    pixel_t pix;
    int gap;
    in_valid <= 1'b1;
    in_operation <= b.op;
    in_start_x <= b.sx;
    in_start_y <= b.sy;
    in_end_x <= b.ex;
    in_end_y <= b.ey;
    in_pixel_color <= b.color;
    do @(posedge clk); while (!in_ready);
    rasterize_beat(b, has_pixel, pix);
    if (b.kind == ROW_TYPED) pending_pixels.push_back(b.want);
    else if (b.kind == ROW_PREDICT && has_pixel) pending_pixels.push_back(pix);
    gap = (idling_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (!stalls_on || $urandom_range(0, 1) == 0) begin
      out_ready <= 1'b1;
      ready_hold <= $urandom_range(0, 12);
    end else begin
      out_ready <= 1'b0;
      ready_hold <= pick_gap();
    end
  end

  always @(posedge clk) begin
    pixel_t got;
    pixel_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_pixel_x, out_pixel_y, out_color, out_last_pixel};
      if (pending_pixels.size() == 0) begin
        note_mismatch($sformatf("unexpected pixel x=%0d y=%0d color=%06h last=%0d",
                                got.x, got.y, got.color, got.last));
      end else begin
        want = pending_pixels.pop_front();
        if (got !== want)
          note_mismatch($sformatf(
            "pixel mismatch: exp %0d,%0d %06h last %0d, got %0d,%0d %06h last %0d",
            want.x, want.y, want.color, want.last, got.x, got.y, got.color, got.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    stim_row_t b;
    int random_beats;
    int sx;
    int sy;
    int ex;
    int ey;
    int len;
    int steps;
    int pick;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = OP_START;
    in_start_x = '0;
    in_start_y = '0;
    in_end_x = '0;
    in_end_y = '0;
    in_pixel_color = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) send_beat(directed_rows[i]);

    random_beats = 0;
    while (random_beats < RANDOM_BEATS) begin
      idling_on = ((random_beats / 250) % 4) != 3;
      stalls_on = idling_on;
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        // stray beat of either kind
        b = '{1'($urandom_range(0, 1)), coord_t'($urandom), coord_t'($urandom),
              coord_t'($urandom), coord_t'($urandom), color_t'($urandom),
              ROW_PREDICT, NO_PIXEL};
        send_beat(b);
        random_beats++;
        continue;
      end
      sx = $urandom_range(0, COORD_MAX);
      sy = $urandom_range(0, COORD_MAX);
      if (pick < 70) begin
        ex = near_coord(sx);
        ey = near_coord(sy);
      end else if (pick < 80) begin
        sx = $urandom_range(0, 1) ? $urandom_range(0, 3)
                                  : $urandom_range(COORD_MAX - 3, COORD_MAX);
        sy = $urandom_range(0, 1) ? $urandom_range(0, 3)
                                  : $urandom_range(COORD_MAX - 3, COORD_MAX);
        ex = near_coord(sx);
        ey = near_coord(sy);
      end else if (pick < 95) begin
        ex = $urandom_range(0, COORD_MAX);
        ey = $urandom_range(0, COORD_MAX);
      end else begin
        ex = sx;
        ey = sy;
      end
      len = (ex > sx ? ex - sx : sx - ex);
      if ((ey > sy ? ey - sy : sy - ey) > len) len = ey > sy ? ey - sy : sy - ey;
      pick = $urandom_range(0, 9);
      if (pick < 6) steps = len;
      else if (pick < 8) steps = len + $urandom_range(1, 3);
      else steps = $urandom_range(0, len);
      if (steps > 48 && $urandom_range(0, 49) != 0) steps = $urandom_range(1, 48);

      b = '{OP_START, coord_t'(sx), coord_t'(sy), coord_t'(ex), coord_t'(ey),
            color_t'($urandom), ROW_PREDICT, NO_PIXEL};
      send_beat(b);
      random_beats++;
      for (int i = 0; i < steps; i++) begin
        b = '{OP_STEP, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
              coord_t'($urandom), color_t'($urandom), ROW_PREDICT, NO_PIXEL};
        send_beat(b);
        random_beats++;
      end
    end
    in_valid <= 1'b0;

    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/dda_pkg.sv
rtl/dda_line_rasterizer_core.sv
tb/dda_line_rasterizer_core_tb.sv
